// ===== rtl/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types and constants of the grid ray caster.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int MAP_W      = 6;
  localparam int ADDR_W     = 2 * MAP_W;
  localparam int COL_W      = 10;
  localparam int POS_W      = 22;
  localparam int VEC_W      = 18;
  localparam int FRAC_BITS  = 16;
  localparam int CELL_W     = 8;
  localparam int ROW_W      = 9;
  localparam int DIV_W      = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;

  // The column times 2^17 over the screen width equals the column times
  // CAM_RECIP shifted right by CAM_SHIFT for every 10-bit column.
  localparam int CAM_RECIP = 838861;
  localparam int CAM_SHIFT = 12;

  localparam logic [31:0]    STEP_SAT = 32'hFFFF_FFFF;
  localparam logic [POS_W-1:0] DIST_MAX = 22'h3F_FFFF;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CAST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y = 3'd5;

  typedef struct packed {
    logic              req_type;
    logic [COL_W-1:0]  column;
    logic [MAP_W-1:0]  cell_x;
    logic [MAP_W-1:0]  cell_y;
    logic [CELL_W-1:0] cell_value;
  } grc_req_t;

  typedef struct packed {
    logic [COL_W-1:0]  column_out;
    logic [MAP_W-1:0]  hit_x;
    logic [MAP_W-1:0]  hit_y;
    logic [CELL_W-1:0] wall_value;
    logic              hit_side;
    logic [POS_W-1:0]  wall_distance;
    logic [ROW_W-1:0]  row_top;
    logic [ROW_W-1:0]  row_bottom;
    logic              left_map;
  } grc_res_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CAM, ST_MULX, ST_MULY, ST_RAY, ST_DIVX, ST_DIVY,
    ST_SDX, ST_SDY, ST_SDY2, ST_WSTEP, ST_WREAD, ST_DIST, ST_LH, ST_OUT
  } grc_state_t;

endpackage

// ===== rtl/grc_chan_if.sv =====
// ----------------------------------------------------------------------------
// grc_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface grc_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/grc_div.sv =====
// ----------------------------------------------------------------------------
// grc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div import grc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             done
);

  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   dvs;
  logic [5:0]         cnt;
  logic               busy;
  logic [DIV_W:0]     shifted;
  logic               fits;

  assign shifted = {rem, quotient[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem      <= DIV_W'(shifted - {1'b0, dvs});
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[DIV_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/grid_ray_cast_dda.sv =====
// ----------------------------------------------------------------------------
// grid_ray_cast_dda
// Grid ray caster: stores a 64x64 cell map and walks one ray per cast
// request with DDA, returning the hit cell, distance and wall slice rows.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload    Notes
//  req       in   grc_req_t  cell write or column cast
//  res       out  grc_res_t  one result per cast
//  cfg_*     in   22 bits    position, direction and plane registers
//
//  A cast runs the setup states CAM, MULX, MULY, RAY, SDX, SDY and SDY2, up
//  to four divisions in the shared 40-bit divider (each skipped when its
//  result is known without it), a step and a read state per cell crossed and
//  one more step to fetch the wall cell. After reset the map is cleared, one
//  cell per cycle, before the first request is taken. The result waits in a
//  register until its transfer; no request is taken meanwhile.
// ----------------------------------------------------------------------------
module grid_ray_cast_dda import grc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  grc_chan_if.sink              req,
  grc_chan_if.source            res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  grc_state_t state, state_next;

  logic [POS_W-1:0]        pos_x, pos_y;
  logic signed [VEC_W-1:0] dir_x, dir_y, plane_x, plane_y;

  logic [CELL_W-1:0] grid_mem [2**ADDR_W];
  logic [CELL_W-1:0] mem_q;
  logic [ADDR_W-1:0] clr_cnt;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  logic [COL_W-1:0]    col;
  logic signed [19:0]  cam;
  logic signed [19:0]  cam_calc;
  logic signed [53:0]  prod;
  logic signed [19:0]  mul_a;
  logic signed [33:0]  mul_b;
  logic signed [21:0]  rx, ry;
  logic [31:0]         dx, dy;
  logic [47:0]         sdx, sdy;
  logic signed [7:0]   mx, my;
  logic                side, left, first, launched;
  logic [CELL_W-1:0]   wall;
  logic [DIV_W-1:0]    perp;
  grc_res_t            res_q;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dvd, div_dvs, div_q;

  logic [16:0]        frac_x, frac_y;
  logic [21:0]        rx_mag, ry_mag;
  logic signed [21:0] ray;
  logic [21:0]        ray_mag;
  logic signed [25:0] num;
  logic [25:0]        num_mag;
  logic               ray_zero, dist_zero, dist_bypass, out_map;
  logic [DIV_W-1:0]   half;

  assign cam_calc = $signed({2'b0, prod[CAM_SHIFT+17:CAM_SHIFT]}) - 20'sd65536;
  assign rx_mag   = rx[21] ? 22'(-rx) : 22'(rx);
  assign ry_mag   = ry[21] ? 22'(-ry) : 22'(ry);
  assign frac_x   = rx[21] ? {1'b0, pos_x[15:0]} : 17'h1_0000 - {1'b0, pos_x[15:0]};
  assign frac_y   = ry[21] ? {1'b0, pos_y[15:0]} : 17'h1_0000 - {1'b0, pos_y[15:0]};
  assign ray      = side ? ry : rx;
  assign ray_mag  = side ? ry_mag : rx_mag;
  assign num      = side ?
      {{2{my[7]}}, my, 16'b0} - $signed({4'b0, pos_y}) + (ry[21] ? 26'sd65536 : 26'sd0) :
      {{2{mx[7]}}, mx, 16'b0} - $signed({4'b0, pos_x}) + (rx[21] ? 26'sd65536 : 26'sd0);
  assign num_mag  = num[25] ? 26'(-num) : 26'(num);
  assign ray_zero = (ray == '0);
  assign dist_zero   = (num[25] != ray[21]) && (num != '0);
  assign dist_bypass = ray_zero || dist_zero;
  assign out_map  = (mx[7:6] != 2'b00) || (my[7:6] != 2'b00);
  assign half     = div_q >> 1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= 22'd98304;
      pos_y   <= 22'd98304;
      dir_x   <= -18'sd65536;
      dir_y   <= '0;
      plane_x <= '0;
      plane_y <= 18'sd43254;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POS_X:   pos_x   <= cfg_data;
        CFG_POS_Y:   pos_y   <= cfg_data;
        CFG_DIR_X:   dir_x   <= cfg_data[VEC_W-1:0];
        CFG_DIR_Y:   dir_y   <= cfg_data[VEC_W-1:0];
        CFG_PLANE_X: plane_x <= cfg_data[VEC_W-1:0];
        CFG_PLANE_Y: plane_y <= cfg_data[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == '1) state_next = ST_IDLE;
      ST_IDLE:  if (req.valid && req.data.req_type == REQ_CAST) state_next = ST_CAM;
      ST_CAM:   state_next = ST_MULX;
      ST_MULX:  state_next = ST_MULY;
      ST_MULY:  state_next = ST_RAY;
      ST_RAY:   state_next = ST_DIVX;
      ST_DIVX:  if (rx == '0 || div_done) state_next = ST_DIVY;
      ST_DIVY:  if (ry == '0 || div_done) state_next = ST_SDX;
      ST_SDX:   state_next = ST_SDY;
      ST_SDY:   state_next = ST_SDY2;
      ST_SDY2:  state_next = ST_WSTEP;
      ST_WSTEP: state_next = (!first && mem_q != '0) ? ST_DIST : ST_WREAD;
      ST_WREAD: state_next = out_map ? ST_DIST : ST_WSTEP;
      ST_DIST:  if (dist_bypass || div_done) state_next = ST_LH;
      ST_LH:    if (perp == '0 || div_done) state_next = ST_OUT;
      ST_OUT:   if (res.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    req.ready = (state == ST_IDLE);
    res.valid = (state == ST_OUT);
    res.data  = res_q;
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    mul_a     = cam;
    mul_b     = 34'(plane_x);
    unique case (state)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE: begin
        mem_we    = req.valid && req.data.req_type == REQ_WRITE;
        mem_waddr = {req.data.cell_x, req.data.cell_y};
        mem_wdata = req.data.cell_value;
      end
      ST_CAM: begin
        mul_a = $signed({10'b0, col});
        mul_b = 34'(CAM_RECIP);
      end
      ST_MULX: mul_a = cam_calc;
      ST_MULY: mul_b = 34'(plane_y);
      ST_DIVX: begin
        div_start = !launched && rx != '0;
        div_dvd   = DIV_W'(64'h1_0000_0000);
        div_dvs   = DIV_W'(rx_mag);
      end
      ST_DIVY: begin
        div_start = !launched && ry != '0;
        div_dvd   = DIV_W'(64'h1_0000_0000);
        div_dvs   = DIV_W'(ry_mag);
      end
      ST_SDX: begin
        mul_a = $signed({3'b0, frac_x});
        mul_b = $signed({2'b0, dx});
      end
      ST_SDY: begin
        mul_a = $signed({3'b0, frac_y});
        mul_b = $signed({2'b0, dy});
      end
      ST_DIST: begin
        div_start = !launched && !dist_bypass;
        div_dvd   = {num_mag[23:0], 16'b0};
        div_dvs   = DIV_W'(ray_mag);
      end
      ST_LH: begin
        div_start = !launched && perp != '0;
        div_dvd   = DIV_W'(SCREEN_HEIGHT) << FRAC_BITS;
        div_dvs   = perp;
      end
      default: ;
    endcase
  end

  grc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
    mem_q <= grid_mem[{mx[5:0], my[5:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (div_start) launched <= 1'b1;
      else if (div_done) launched <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: col <= req.data.column;
      ST_CAM:  prod <= mul_a * mul_b;
      ST_MULX: begin
        cam  <= cam_calc;
        prod <= mul_a * mul_b;
      end
      ST_MULY: begin
        rx   <= 22'(dir_x) + prod[37:16];
        prod <= mul_a * mul_b;
      end
      ST_RAY: begin
        ry    <= 22'(dir_y) + prod[37:16];
        mx    <= {2'b0, pos_x[21:16]};
        my    <= {2'b0, pos_y[21:16]};
        first <= 1'b1;
        left  <= 1'b0;
        wall  <= '0;
        side  <= 1'b0;
      end
      ST_DIVX: begin
        if (rx == '0) dx <= STEP_SAT;
        else if (div_done) dx <= (div_q > DIV_W'(STEP_SAT)) ? STEP_SAT : div_q[31:0];
      end
      ST_DIVY: begin
        if (ry == '0) dy <= STEP_SAT;
        else if (div_done) dy <= (div_q > DIV_W'(STEP_SAT)) ? STEP_SAT : div_q[31:0];
      end
      ST_SDX: prod <= mul_a * mul_b;
      ST_SDY: begin
        sdx  <= 48'(prod[53:16]);
        prod <= mul_a * mul_b;
      end
      ST_SDY2: sdy <= 48'(prod[53:16]);
      ST_WSTEP: begin
        first <= 1'b0;
        if (!first && mem_q != '0) begin
          wall <= mem_q;
        end else if (sdx < sdy) begin
          sdx  <= sdx + 48'(dx);
          mx   <= rx[21] ? mx - 8'sd1 : mx + 8'sd1;
          side <= 1'b0;
        end else begin
          sdy  <= sdy + 48'(dy);
          my   <= ry[21] ? my - 8'sd1 : my + 8'sd1;
          side <= 1'b1;
        end
      end
      ST_WREAD: if (out_map) left <= 1'b1;
      ST_DIST: begin
        if (ray_zero) perp <= DIV_W'(DIST_MAX);
        else if (dist_zero) perp <= '0;
        else if (div_done) perp <= div_q;
      end
      ST_LH: begin
        if (perp == '0 || div_done) begin
          res_q.column_out    <= col;
          res_q.hit_x         <= mx[7] ? '0 : (mx[6] ? '1 : mx[5:0]);
          res_q.hit_y         <= my[7] ? '0 : (my[6] ? '1 : my[5:0]);
          res_q.wall_value    <= left ? '0 : wall;
          res_q.hit_side      <= side;
          res_q.wall_distance <= (perp > DIV_W'(DIST_MAX)) ? DIST_MAX : perp[POS_W-1:0];
          res_q.left_map      <= left;
          if (perp == '0) begin
            res_q.row_top    <= '0;
            res_q.row_bottom <= ROW_W'(SCREEN_HEIGHT - 1);
          end else begin
            res_q.row_top    <= (half > DIV_W'(SCREEN_HEIGHT / 2)) ? '0 :
                ROW_W'(DIV_W'(SCREEN_HEIGHT / 2) - half);
            res_q.row_bottom <= (half >= DIV_W'(SCREEN_HEIGHT / 2)) ?
                ROW_W'(SCREEN_HEIGHT - 1) : ROW_W'(half + DIV_W'(SCREEN_HEIGHT / 2));
          end
        end
      end
      default: ;
    endcase
  end

  // The input is never taken while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
      res.valid |-> !req.ready)
    else $error("request taken while a result is pending");

  // Slice rows are ordered.
  a_rows: assert property (@(posedge clk) disable iff (rst)
      res.valid |-> res.data.row_top <= res.data.row_bottom)
    else $error("top row of the slice below its bottom row");

  // Leaving the grid reports an empty cell.
  a_left: assert property (@(posedge clk) disable iff (rst)
      (res.valid && res.data.left_map) |-> res.data.wall_value == '0)
    else $error("wall value set on a ray that left the grid");

  // Reset starts the map clearing pass.
  a_clear: assert property (@(posedge clk)
      rst |=> (state == ST_CLEAR && clr_cnt == '0))
    else $error("reset did not start the clearing pass");

endmodule

// ===== tb/grid_ray_cast_dda_test.sv =====
// ----------------------------------------------------------------------------
// grid_ray_cast_dda_test
// Self-checking bench for the grid ray caster. It fills the cell map, casts
// columns under several camera settings, and checks each result against a
// DDA walk that it computes itself. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module grid_ray_cast_dda_test;
  import grc_pkg::*;

  localparam longint ONE = 65536;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  grc_chan_if #(.payload_t(grc_req_t)) req_ch ();
  grc_chan_if #(.payload_t(grc_res_t)) res_ch ();

  grid_ray_cast_dda dut (
    .clk(clk), .rst(rst), .req(req_ch), .res(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic [7:0] map_cells [0:4095];
  longint cam_pos_x, cam_pos_y, cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
  grc_res_t pending_hits [$];
  int errors = 0;
  int burst_left = 0;
  int hold_request = 0;
  int hold_cycles = 0;
  int stall_mode = 0;
  longint cycles = 0;

  function automatic longint step_len(longint r);
    longint q;
    if (r == 0) return longint'(STEP_SAT);
    q = (longint'(1) << 32) / (r < 0 ? -r : r);
    return q > longint'(STEP_SAT) ? longint'(STEP_SAT) : q;
  endfunction

  function automatic logic [5:0] clamp_cell(longint c);
    if (c < 0) return 6'd0;
    if (c > 63) return 6'd63;
    return c[5:0];
  endfunction

  function automatic grc_res_t trace_ray(logic [COL_W-1:0] col);
    longint cam, rx, ry, mx, my, sx, sy, num, ray, frac, dx, dy, sdx, sdy;
    longint span, lh, row_a, row_b;
    logic side, left;
    logic [7:0] wall;
    grc_res_t r;
    side = 1'b0;
    left = 1'b0;
    wall = 8'd0;
    cam = ((2 * longint'(col)) << 16) / SCREEN_WIDTH - ONE;
    rx = cam_dir_x + ((cam_plane_x * cam) >>> 16);
    ry = cam_dir_y + ((cam_plane_y * cam) >>> 16);
    mx = cam_pos_x >> 16;
    my = cam_pos_y >> 16;
    dx = step_len(rx);
    dy = step_len(ry);
    frac = cam_pos_x - (mx << 16);
    if (rx < 0) sx = -1;
    else begin
      sx = 1;
      frac = ONE - frac;
    end
    sdx = (frac * dx) >> 16;
    frac = cam_pos_y - (my << 16);
    if (ry < 0) sy = -1;
    else begin
      sy = 1;
      frac = ONE - frac;
    end
    sdy = (frac * dy) >> 16;
    while (1) begin
      if (sdx < sdy) begin
        sdx += dx;
        mx += sx;
        side = 1'b0;
      end else begin
        sdy += dy;
        my += sy;
        side = 1'b1;
      end
      if (mx < 0 || mx > 63 || my < 0 || my > 63) begin
        left = 1'b1;
        break;
      end
      wall = map_cells[mx * 64 + my];
      if (wall != 0) break;
    end
    if (side == 1'b0) begin
      num = mx * ONE - cam_pos_x + (sx < 0 ? ONE : 0);
      ray = rx;
    end else begin
      num = my * ONE - cam_pos_y + (sy < 0 ? ONE : 0);
      ray = ry;
    end
    if (ray == 0) span = longint'(DIST_MAX);
    else if (((num < 0) != (ray < 0)) && num != 0) span = 0;
    else span = ((num < 0 ? -num : num) << 16) / (ray < 0 ? -ray : ray);
    if (span == 0) begin
      row_a = 0;
      row_b = SCREEN_HEIGHT - 1;
    end else begin
      lh = (longint'(SCREEN_HEIGHT) << 16) / span;
      row_a = (lh / 2 > SCREEN_HEIGHT / 2) ? 0 : SCREEN_HEIGHT / 2 - lh / 2;
      row_b = lh / 2 + SCREEN_HEIGHT / 2;
      if (row_b >= SCREEN_HEIGHT) row_b = SCREEN_HEIGHT - 1;
    end
    r.column_out = col;
    r.hit_x = clamp_cell(mx);
    r.hit_y = clamp_cell(my);
    r.wall_value = left ? 8'd0 : wall;
    r.hit_side = side;
    r.wall_distance = span > longint'(DIST_MAX) ? DIST_MAX : span[POS_W-1:0];
    r.row_top = row_a[ROW_W-1:0];
    r.row_bottom = row_b[ROW_W-1:0];
    r.left_map = left;
    return r;
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POS_X: cam_pos_x = longint'(value);
      CFG_POS_Y: cam_pos_y = longint'(value);
      CFG_DIR_X: cam_dir_x = longint'($signed(value[VEC_W-1:0]));
      CFG_DIR_Y: cam_dir_y = longint'($signed(value[VEC_W-1:0]));
      CFG_PLANE_X: cam_plane_x = longint'($signed(value[VEC_W-1:0]));
      CFG_PLANE_Y: cam_plane_y = longint'($signed(value[VEC_W-1:0]));
      default: ;
    endcase
  endtask

  task automatic set_camera(logic [21:0] px, logic [21:0] py, logic [17:0] dxv,
                            logic [17:0] dyv, logic [17:0] plx, logic [17:0] ply);
    cfg_write(CFG_POS_X, px);
    cfg_write(CFG_POS_Y, py);
    cfg_write(CFG_DIR_X, {4'd0, dxv});
    cfg_write(CFG_DIR_Y, {4'd0, dyv});
    cfg_write(CFG_PLANE_X, {4'd0, plx});
    cfg_write(CFG_PLANE_Y, {4'd0, ply});
  endtask

  task automatic send_req(grc_req_t r);
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    if (r.req_type == REQ_WRITE) map_cells[{r.cell_x, r.cell_y}] = r.cell_value;
    else pending_hits.push_back(trace_ray(r.column));
    if (burst_left > 0) burst_left--;
    else begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic write_cell(logic [5:0] x, logic [5:0] y, logic [7:0] v);
    grc_req_t r;
    r = grc_req_t'({$urandom, $urandom});
    r.req_type = REQ_WRITE;
    r.cell_x = x;
    r.cell_y = y;
    r.cell_value = v;
    send_req(r);
  endtask

  task automatic cast_column(logic [COL_W-1:0] col);
    grc_req_t r;
    r = grc_req_t'({$urandom, $urandom});
    r.req_type = REQ_CAST;
    r.column = col;
    send_req(r);
  endtask

  task automatic drain;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_hits.size() == 0);
    @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed;
    cast_column(10'd0);
    cast_column(10'd320);
    cast_column(10'd639);
    cast_column(10'd1023);
    write_cell(6'd0, 6'd1, 8'd255);
    write_cell(6'd63, 6'd63, 8'd1);
    write_cell(6'd0, 6'd2, 8'd7);
    write_cell(6'd0, 6'd1, 8'd0);
    cast_column(10'd320);
    cast_column(10'd100);
    drain();
    set_camera(22'd131072, 22'd98304, 18'h30000, 18'd0, 18'd0, 18'd43254);
    write_cell(6'd1, 6'd1, 8'd9);
    cast_column(10'd320);
    cast_column(10'd600);
    drain();
    set_camera(22'h3FFFFF, 22'h3FFFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
    cast_column(10'd0);
    cast_column(10'd1023);
    drain();
    set_camera(22'd0, 22'd0, 18'h20000, 18'h20000, 18'h20000, 18'h20000);
    cast_column(10'd0);
    cast_column(10'd639);
    drain();
  endtask

  task automatic test_random_scenes(int scenes);
    int walls, casts;
    for (int s = 0; s < scenes; s++) begin
      if ($urandom_range(0, 3) == 0)
        set_camera(22'($urandom), 22'($urandom), 18'($urandom), 18'($urandom),
                   18'($urandom), 18'($urandom));
      else
        set_camera(22'({6'($urandom_range(0, 63)), 16'($urandom)}),
                   22'({6'($urandom_range(0, 63)), 16'($urandom)}),
                   18'($signed($urandom_range(0, 196608)) - 98304),
                   18'($signed($urandom_range(0, 196608)) - 98304),
                   18'($signed($urandom_range(0, 131072)) - 65536),
                   18'($signed($urandom_range(0, 131072)) - 65536));
      walls = $urandom_range(20, 70);
      for (int i = 0; i < walls; i++)
        write_cell(6'($urandom), 6'($urandom),
                   ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom));
      casts = $urandom_range(20, 40);
      for (int i = 0; i < casts; i++)
        cast_column(($urandom_range(0, 9) == 0) ? 10'($urandom) :
                    10'($urandom_range(0, 639)));
      drain();
    end
  endtask

  task automatic test_backpressure;
    hold_request = 1;
    for (int i = 0; i < 20; i++) cast_column(10'($urandom_range(0, 639)));
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_request != 0) begin
      hold_request = 0;
      hold_cycles = 3000;
      res_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      res_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 255) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= 1'($urandom_range(0, 1));
        default: res_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    grc_res_t e, a;
    if (!rst && res_ch.valid && res_ch.ready) begin
      a = res_ch.data;
      if (pending_hits.size() == 0) begin
        $error("result for column %0d with none expected", a.column_out);
        errors++;
      end else begin
        e = pending_hits.pop_front();
        check_field("column_out", e.column_out, a.column_out);
        check_field("hit_x", e.hit_x, a.hit_x);
        check_field("hit_y", e.hit_y, a.hit_y);
        check_field("wall_value", e.wall_value, a.wall_value);
        check_field("hit_side", e.hit_side, a.hit_side);
        check_field("wall_distance", e.wall_distance, a.wall_distance);
        check_field("row_top", e.row_top, a.row_top);
        check_field("row_bottom", e.row_bottom, a.row_bottom);
        check_field("left_map", e.left_map, a.left_map);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 4096; i++) map_cells[i] = 8'd0;
    cam_pos_x = 98304;
    cam_pos_y = 98304;
    cam_dir_x = -65536;
    cam_dir_y = 0;
    cam_plane_x = 0;
    cam_plane_y = 43254;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random_scenes(20);
    test_backpressure();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== grid_ray_cast_dda.f =====
rtl/grc_pkg.sv
rtl/grc_chan_if.sv
rtl/grc_div.sv
rtl/grid_ray_cast_dda.sv
tb/grid_ray_cast_dda_test.sv
